// ===== rtl/esdp_pkg.sv =====
package esdp_pkg;

    typedef enum logic [4:0] {
        PH_TOP_TAG,
        PH_TOP_LEN,
        PH_ES_ID,
        PH_FLAGS,
        PH_DEP,
        PH_URL_LEN,
        PH_URL,
        PH_OCR,
        PH_DC_TAG,
        PH_DC_LEN,
        PH_OTI,
        PH_STYPE,
        PH_SKIP11,
        PH_DSI_TAG,
        PH_DSI_LEN,
        PH_REST,
        PH_ERROR
    } phase_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_TRUNCATED   = 3'd1;
    localparam status_t ST_BAD_TOP_TAG = 3'd2;
    localparam status_t ST_BAD_DC      = 3'd3;
    localparam status_t ST_VISUAL      = 3'd4;
    localparam status_t ST_AAC_13818   = 3'd5;
    localparam status_t ST_UNSUPPORTED = 3'd6;
    localparam status_t ST_BAD_DSI     = 3'd7;

    localparam logic [7:0] TAG_ES  = 8'h03;
    localparam logic [7:0] TAG_DC  = 8'h04;
    localparam logic [7:0] TAG_DSI = 8'h05;

    localparam logic [7:0] OT_AAC = 8'h40;

    localparam int LEN_BITS    = 28;
    localparam int EXTRA_BITS  = 48;
    localparam int BASE_BITS   = 48;
    localparam int STYPE_BITS  = 6;
    localparam int SKIP_BITS   = 8;
    localparam int ID_SKIP     = 2;
    localparam int DC_SKIP     = 11;

endpackage

// ===== rtl/esdp_byte_if.sv =====
interface esdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/esdp_result_if.sv =====
interface esdp_result_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          status;
    logic                                is_mp3;
    logic [7:0]                          object_type;
    logic [esdp_pkg::STYPE_BITS-1:0]     stream_type;
    logic [esdp_pkg::EXTRA_BITS-1:0]     extra_offset;
    logic [esdp_pkg::LEN_BITS-1:0]       extra_length;

    modport source (output valid, output status, output is_mp3, output object_type,
                    output stream_type, output extra_offset, output extra_length,
                    input ready);
    modport sink   (input valid, input status, input is_mp3, input object_type,
                    input stream_type, input extra_offset, input extra_length,
                    output ready);
endinterface

// ===== rtl/es_descriptor_parser.sv =====
// Streaming esds payload parser. Takes one payload byte per cycle on the
// payload channel (last_byte marks the final byte of an atom) and gives at
// most one status request per atom on the result channel: at the first error,
// or at the last byte. All parse state is updated in the cycle a byte is
// accepted, so a byte can be taken every cycle. The status request sits in an
// output register from the cycle after the deciding byte. Input is stalled
// only while that register is full and the receiver is not taking it, so
// bytes flow back to back as long as each status request is taken when
// offered. base_offset (APB, address 0) is added to the payload position of
// the decoder specific info bytes.
module es_descriptor_parser #(
    parameter int MAX_LENGTH_GROUPS = 4,
    parameter int OFFSET_BITS       = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    esdp_byte_if.sink            payload,
    esdp_result_if.source        result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int GW = $clog2(MAX_LENGTH_GROUPS + 1);
    localparam logic [GW-1:0] MAX_GROUPS = GW'(MAX_LENGTH_GROUPS);

    logic [esdp_pkg::BASE_BITS-1:0] base_offset_reg;

    esdp_pkg::phase_t                 phase_reg, phase_next;
    logic [esdp_pkg::LEN_BITS-1:0]    acc_reg, acc_next;
    logic [GW-1:0]                    grp_reg, grp_next;
    logic [esdp_pkg::SKIP_BITS-1:0]   skip_reg, skip_next;
    logic [2:0]                       flags_reg, flags_next;
    logic [7:0]                       tag_reg, tag_next;
    logic [OFFSET_BITS-1:0]           pos_reg, pos_next;
    logic [7:0]                       obj_reg, obj_next;
    logic [esdp_pkg::STYPE_BITS-1:0]  st_reg, st_next;
    logic [OFFSET_BITS-1:0]           off_reg, off_next;
    logic [esdp_pkg::LEN_BITS-1:0]    len_reg, len_next;
    logic                             mp3_reg, mp3_next;

    logic                             out_valid_reg;
    esdp_pkg::status_t                out_status_reg;
    logic                             out_mp3_reg;
    logic [7:0]                       out_obj_reg;
    logic [esdp_pkg::STYPE_BITS-1:0]  out_st_reg;
    logic [esdp_pkg::EXTRA_BITS-1:0]  out_off_reg;
    logic [esdp_pkg::LEN_BITS-1:0]    out_len_reg;

    logic                             accept;
    logic [7:0]                       b;
    logic                             last;
    logic [esdp_pkg::LEN_BITS-1:0]    acc_shift;
    logic [GW-1:0]                    grp_inc;
    logic                             len_done;
    logic [esdp_pkg::SKIP_BITS-1:0]   skip_dec;
    logic                             skip_zero;
    logic [OFFSET_BITS-1:0]           base_w;
    logic [OFFSET_BITS-1:0]           dsi_offset;
    logic                             err;
    esdp_pkg::status_t                err_code;
    logic                             res_valid;
    esdp_pkg::status_t                res_status;
    logic                             clear;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? 64'(base_offset_reg) : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[3] == 1'b0)
        begin
            base_offset_reg <= pwdata[esdp_pkg::BASE_BITS-1:0];
        end
    end

    assign payload.ready = !out_valid_reg || result.ready;
    assign accept        = payload.valid && payload.ready;
    assign b             = payload.data_byte;
    assign last          = payload.last_byte;

    assign acc_shift  = {acc_reg[esdp_pkg::LEN_BITS-8:0], b[6:0]};
    assign grp_inc    = grp_reg + 1'b1;
    assign len_done   = !b[7] || (grp_inc >= MAX_GROUPS);
    assign skip_dec   = skip_reg - 1'b1;
    assign skip_zero  = (skip_dec == '0);
    assign base_w     = OFFSET_BITS'(base_offset_reg);
    assign dsi_offset = base_w + pos_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        grp_next   = grp_reg;
        skip_next  = skip_reg;
        flags_next = flags_reg;
        tag_next   = tag_reg;
        obj_next   = obj_reg;
        st_next    = st_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        mp3_next   = mp3_reg;
        err        = 1'b0;
        err_code   = esdp_pkg::ST_OK;

        unique case (phase_reg)
            esdp_pkg::PH_TOP_TAG,
            esdp_pkg::PH_DC_TAG,
            esdp_pkg::PH_DSI_TAG:
            begin
                tag_next = b;
                acc_next = '0;
                grp_next = '0;
                priority case (phase_reg)
                    esdp_pkg::PH_TOP_TAG: phase_next = esdp_pkg::PH_TOP_LEN;
                    esdp_pkg::PH_DC_TAG:  phase_next = esdp_pkg::PH_DC_LEN;
                    default:              phase_next = esdp_pkg::PH_DSI_LEN;
                endcase
            end
            esdp_pkg::PH_TOP_LEN:
            begin
                acc_next = acc_shift;
                grp_next = grp_inc;
                if (len_done)
                begin
                    if (tag_reg != esdp_pkg::TAG_ES)
                    begin
                        err      = 1'b1;
                        err_code = esdp_pkg::ST_BAD_TOP_TAG;
                    end
                    else
                    begin
                        phase_next = esdp_pkg::PH_ES_ID;
                        skip_next  = esdp_pkg::SKIP_BITS'(esdp_pkg::ID_SKIP);
                    end
                end
            end
            esdp_pkg::PH_ES_ID:
            begin
                skip_next = skip_dec;
                if (skip_zero)
                begin
                    phase_next = esdp_pkg::PH_FLAGS;
                end
            end
            esdp_pkg::PH_FLAGS:
            begin
                flags_next = b[7:5];
                if (b[7])
                begin
                    phase_next = esdp_pkg::PH_DEP;
                    skip_next  = esdp_pkg::SKIP_BITS'(esdp_pkg::ID_SKIP);
                end
                else if (b[6])
                begin
                    phase_next = esdp_pkg::PH_URL_LEN;
                end
                else if (b[5])
                begin
                    phase_next = esdp_pkg::PH_OCR;
                    skip_next  = esdp_pkg::SKIP_BITS'(esdp_pkg::ID_SKIP);
                end
                else
                begin
                    phase_next = esdp_pkg::PH_DC_TAG;
                end
            end
            esdp_pkg::PH_DEP:
            begin
                skip_next = skip_dec;
                if (skip_zero)
                begin
                    if (flags_reg[1])
                    begin
                        phase_next = esdp_pkg::PH_URL_LEN;
                    end
                    else if (flags_reg[0])
                    begin
                        phase_next = esdp_pkg::PH_OCR;
                        skip_next  = esdp_pkg::SKIP_BITS'(esdp_pkg::ID_SKIP);
                    end
                    else
                    begin
                        phase_next = esdp_pkg::PH_DC_TAG;
                    end
                end
            end
            esdp_pkg::PH_URL_LEN,
            esdp_pkg::PH_URL:
            begin
                if (phase_reg == esdp_pkg::PH_URL_LEN && b != 8'd0)
                begin
                    skip_next  = b;
                    phase_next = esdp_pkg::PH_URL;
                end
                else
                begin
                    skip_next = (phase_reg == esdp_pkg::PH_URL_LEN) ? b : skip_dec;
                    if (phase_reg == esdp_pkg::PH_URL_LEN || skip_zero)
                    begin
                        if (flags_reg[0])
                        begin
                            phase_next = esdp_pkg::PH_OCR;
                            skip_next  = esdp_pkg::SKIP_BITS'(esdp_pkg::ID_SKIP);
                        end
                        else
                        begin
                            phase_next = esdp_pkg::PH_DC_TAG;
                        end
                    end
                end
            end
            esdp_pkg::PH_OCR:
            begin
                skip_next = skip_dec;
                if (skip_zero)
                begin
                    phase_next = esdp_pkg::PH_DC_TAG;
                end
            end
            esdp_pkg::PH_DC_LEN:
            begin
                acc_next = acc_shift;
                grp_next = grp_inc;
                if (len_done)
                begin
                    if (tag_reg != esdp_pkg::TAG_DC || acc_shift == '0)
                    begin
                        err      = 1'b1;
                        err_code = esdp_pkg::ST_BAD_DC;
                    end
                    else
                    begin
                        phase_next = esdp_pkg::PH_OTI;
                    end
                end
            end
            esdp_pkg::PH_OTI:
            begin
                obj_next   = b;
                phase_next = esdp_pkg::PH_STYPE;
            end
            esdp_pkg::PH_STYPE:
            begin
                st_next    = b[7:2];
                phase_next = esdp_pkg::PH_SKIP11;
                skip_next  = esdp_pkg::SKIP_BITS'(esdp_pkg::DC_SKIP);
            end
            esdp_pkg::PH_SKIP11:
            begin
                skip_next = skip_dec;
                if (skip_zero)
                begin
                    unique case (obj_reg)
                        8'h20, 8'h21, 8'h60, 8'h61, 8'h62, 8'h63,
                        8'h64, 8'h65, 8'h6a, 8'h6c, 8'h6e:
                        begin
                            err      = 1'b1;
                            err_code = esdp_pkg::ST_VISUAL;
                        end
                        8'h6b, 8'h69:
                        begin
                            mp3_next   = 1'b1;
                            phase_next = esdp_pkg::PH_REST;
                        end
                        esdp_pkg::OT_AAC:
                        begin
                            phase_next = esdp_pkg::PH_DSI_TAG;
                        end
                        8'h66, 8'h67, 8'h68:
                        begin
                            err      = 1'b1;
                            err_code = esdp_pkg::ST_AAC_13818;
                        end
                        default:
                        begin
                            err      = 1'b1;
                            err_code = esdp_pkg::ST_UNSUPPORTED;
                        end
                    endcase
                end
            end
            esdp_pkg::PH_DSI_LEN:
            begin
                acc_next = acc_shift;
                grp_next = grp_inc;
                if (len_done)
                begin
                    if (tag_reg != esdp_pkg::TAG_DSI || acc_shift == '0)
                    begin
                        err      = 1'b1;
                        err_code = esdp_pkg::ST_BAD_DSI;
                    end
                    else
                    begin
                        off_next   = dsi_offset;
                        len_next   = acc_shift;
                        phase_next = esdp_pkg::PH_REST;
                    end
                end
            end
            esdp_pkg::PH_REST,
            esdp_pkg::PH_ERROR:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // result decision
    always_comb
    begin
        res_valid  = 1'b0;
        res_status = esdp_pkg::ST_OK;
        clear      = last;
        if (phase_reg == esdp_pkg::PH_ERROR)
        begin
            res_valid = 1'b0;
        end
        else if (err)
        begin
            res_valid  = 1'b1;
            res_status = err_code;
        end
        else if (last)
        begin
            res_valid  = 1'b1;
            res_status = (phase_next == esdp_pkg::PH_REST) ? esdp_pkg::ST_OK
                                                            : esdp_pkg::ST_TRUNCATED;
        end
        pos_next = pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esdp_pkg::PH_TOP_TAG;
            acc_reg   <= '0;
            grp_reg   <= '0;
            skip_reg  <= '0;
            flags_reg <= '0;
            tag_reg   <= '0;
            pos_reg   <= '0;
            obj_reg   <= '0;
            st_reg    <= '0;
            off_reg   <= '0;
            len_reg   <= '0;
            mp3_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (clear)
            begin
                phase_reg <= esdp_pkg::PH_TOP_TAG;
                acc_reg   <= '0;
                grp_reg   <= '0;
                skip_reg  <= '0;
                flags_reg <= '0;
                tag_reg   <= '0;
                pos_reg   <= '0;
                obj_reg   <= '0;
                st_reg    <= '0;
                off_reg   <= '0;
                len_reg   <= '0;
                mp3_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= err ? esdp_pkg::PH_ERROR : phase_next;
                acc_reg   <= acc_next;
                grp_reg   <= grp_next;
                skip_reg  <= skip_next;
                flags_reg <= flags_next;
                tag_reg   <= tag_next;
                pos_reg   <= pos_next;
                obj_reg   <= obj_next;
                st_reg    <= st_next;
                off_reg   <= off_next;
                len_reg   <= len_next;
                mp3_reg   <= mp3_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_status_reg <= res_status;
            out_mp3_reg    <= mp3_next;
            out_obj_reg    <= obj_next;
            out_st_reg     <= st_next;
            out_off_reg    <= esdp_pkg::EXTRA_BITS'(off_next);
            out_len_reg    <= len_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.is_mp3       = out_mp3_reg;
    assign result.object_type  = out_obj_reg;
    assign result.stream_type  = out_st_reg;
    assign result.extra_offset = out_off_reg;
    assign result.extra_length = out_len_reg;

endmodule

// ===== rtl/esdp_checker.sv =====
module esdp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] res_status,
    input logic       res_mp3
);

    logic stall_reg;
    logic fresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_reg <= 1'b0;
        end
        else
        begin
            stall_reg <= res_valid && !res_ready;
        end
    end

    assign fresh = res_valid && !stall_reg;

    // a stalled result is never overwritten by a new byte
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(res_valid && !res_ready))
        else $error("byte accepted while result stalled");

    // every new result comes from a byte accepted the cycle before
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        fresh |-> $past(in_valid && in_ready))
        else $error("result without accepted byte");

    // ok and truncated are only decided on the last byte
    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh && (res_status == esdp_pkg::ST_OK || res_status == esdp_pkg::ST_TRUNCATED))
        |-> $past(in_last))
        else $error("end status without last byte");

    // an mp3 stream can only end well
    a_mp3_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_mp3) |-> (res_status == esdp_pkg::ST_OK))
        else $error("mp3 flag with error status");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_status)))
        else $error("stalled result dropped or changed");

endmodule

bind es_descriptor_parser esdp_checker u_esdp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (payload.valid),
    .in_ready   (payload.ready),
    .in_last    (payload.last_byte),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_mp3    (result.is_mp3)
);

// ===== test/es_descriptor_parser_test.sv =====
`timescale 1ns / 100ps

localparam int MAX_SIZE_GROUPS = 4;

localparam logic [2:0] FLAG_NONE = 3'b000;
localparam logic [2:0] FLAG_OCR  = 3'b001;
localparam logic [2:0] FLAG_URL  = 3'b010;
localparam logic [2:0] FLAG_DEP  = 3'b100;

localparam logic [7:0] OT_FORBIDDEN        = 8'h00;
localparam logic [7:0] OT_MPEG4_VISUAL     = 8'h20;
localparam logic [7:0] OT_AVC              = 8'h21;
localparam logic [7:0] OT_MPEG2_VIS_SIMPLE = 8'h60;
localparam logic [7:0] OT_MPEG2_VIS_MAIN   = 8'h61;
localparam logic [7:0] OT_MPEG2_VIS_SNR    = 8'h62;
localparam logic [7:0] OT_MPEG2_VIS_SPAT   = 8'h63;
localparam logic [7:0] OT_MPEG2_VIS_HIGH   = 8'h64;
localparam logic [7:0] OT_MPEG2_VIS_422    = 8'h65;
localparam logic [7:0] OT_AAC_MAIN         = 8'h66;
localparam logic [7:0] OT_AAC_LC           = 8'h67;
localparam logic [7:0] OT_AAC_SSR          = 8'h68;
localparam logic [7:0] OT_MPEG2_AUDIO      = 8'h69;
localparam logic [7:0] OT_MPEG1_VISUAL     = 8'h6a;
localparam logic [7:0] OT_MPEG1_AUDIO      = 8'h6b;
localparam logic [7:0] OT_JPEG             = 8'h6c;
localparam logic [7:0] OT_JPEG2000         = 8'h6e;
localparam logic [7:0] OT_UNSPECIFIED      = 8'hff;

typedef struct packed {
    esdp_pkg::status_t status;
    logic              is_mp3;
    logic [7:0]        object_type;
    logic [5:0]        stream_type;
    logic [47:0]       extra_offset;
    logic [27:0]       extra_length;
} esds_status_t;

class esds_parse_tracker;
    esdp_pkg::phase_t phase;
    logic [27:0]      len_acc;
    logic [2:0]       len_groups;
    logic [7:0]       skip_left;
    logic [2:0]       flags;
    logic [47:0]      pos;
    logic [7:0]       obj_type;
    logic [5:0]       strm_type;
    logic [47:0]      dsi_offset;
    logic [27:0]      dsi_length;
    logic             mp3;
    logic [7:0]       tag;
    logic [47:0]      base_offset;
    esds_status_t     awaited_status[$];
    int               mismatches;

    function new();
        base_offset = '0;
        mismatches  = 0;
        restart();
    endfunction

    function void restart();
        phase      = esdp_pkg::PH_TOP_TAG;
        len_acc    = '0;
        len_groups = '0;
        skip_left  = '0;
        flags      = '0;
        pos        = '0;
        obj_type   = '0;
        strm_type  = '0;
        dsi_offset = '0;
        dsi_length = '0;
        mp3        = 1'b0;
        tag        = '0;
    endfunction

    function void open_tag(esdp_pkg::phase_t next, logic [7:0] b);
        tag        = b;
        len_acc    = '0;
        len_groups = '0;
        phase      = next;
    endfunction

    // one 7-bit size group; 1 when the size is complete
    function bit size_byte(logic [7:0] b);
        len_acc    = {len_acc[20:0], b[6:0]};
        len_groups = len_groups + 1'b1;
        return !b[7] || len_groups >= MAX_SIZE_GROUPS;
    endfunction

    function void enter_ocr();
        if ((flags & FLAG_OCR) != 0)
        begin
            phase     = esdp_pkg::PH_OCR;
            skip_left = 8'(esdp_pkg::ID_SKIP);
        end
        else
            phase = esdp_pkg::PH_DC_TAG;
    endfunction

    function void enter_url();
        if ((flags & FLAG_URL) != 0)
            phase = esdp_pkg::PH_URL_LEN;
        else
            enter_ocr();
    endfunction

    // 1 when the byte ends the parse with an error code
    function bit parse_byte(logic [7:0] b, output esdp_pkg::status_t code);
        code = esdp_pkg::ST_OK;
        case (phase)
            esdp_pkg::PH_TOP_TAG: open_tag(esdp_pkg::PH_TOP_LEN, b);
            esdp_pkg::PH_TOP_LEN:
                if (size_byte(b))
                begin
                    if (tag != esdp_pkg::TAG_ES)
                    begin
                        code = esdp_pkg::ST_BAD_TOP_TAG;
                        return 1'b1;
                    end
                    phase     = esdp_pkg::PH_ES_ID;
                    skip_left = 8'(esdp_pkg::ID_SKIP);
                end
            esdp_pkg::PH_ES_ID:
            begin
                skip_left--;
                if (skip_left == 0)
                    phase = esdp_pkg::PH_FLAGS;
            end
            esdp_pkg::PH_FLAGS:
            begin
                flags = b[7:5];
                if ((flags & FLAG_DEP) != 0)
                begin
                    phase     = esdp_pkg::PH_DEP;
                    skip_left = 8'(esdp_pkg::ID_SKIP);
                end
                else
                    enter_url();
            end
            esdp_pkg::PH_DEP:
            begin
                skip_left--;
                if (skip_left == 0)
                    enter_url();
            end
            esdp_pkg::PH_URL_LEN:
            begin
                skip_left = b;
                if (b == 0)
                    enter_ocr();
                else
                    phase = esdp_pkg::PH_URL;
            end
            esdp_pkg::PH_URL:
            begin
                skip_left--;
                if (skip_left == 0)
                    enter_ocr();
            end
            esdp_pkg::PH_OCR:
            begin
                skip_left--;
                if (skip_left == 0)
                    phase = esdp_pkg::PH_DC_TAG;
            end
            esdp_pkg::PH_DC_TAG: open_tag(esdp_pkg::PH_DC_LEN, b);
            esdp_pkg::PH_DC_LEN:
                if (size_byte(b))
                begin
                    if (tag != esdp_pkg::TAG_DC || len_acc == 0)
                    begin
                        code = esdp_pkg::ST_BAD_DC;
                        return 1'b1;
                    end
                    phase = esdp_pkg::PH_OTI;
                end
            esdp_pkg::PH_OTI:
            begin
                obj_type = b;
                phase    = esdp_pkg::PH_STYPE;
            end
            esdp_pkg::PH_STYPE:
            begin
                strm_type = b[7:2];
                phase     = esdp_pkg::PH_SKIP11;
                skip_left = 8'(esdp_pkg::DC_SKIP);
            end
            esdp_pkg::PH_SKIP11:
            begin
                skip_left--;
                if (skip_left == 0)
                begin
                    case (obj_type)
                        OT_MPEG4_VISUAL, OT_AVC, OT_MPEG2_VIS_SIMPLE, OT_MPEG2_VIS_MAIN,
                        OT_MPEG2_VIS_SNR, OT_MPEG2_VIS_SPAT, OT_MPEG2_VIS_HIGH,
                        OT_MPEG2_VIS_422, OT_MPEG1_VISUAL, OT_JPEG, OT_JPEG2000:
                        begin
                            code = esdp_pkg::ST_VISUAL;
                            return 1'b1;
                        end
                        OT_MPEG1_AUDIO, OT_MPEG2_AUDIO:
                        begin
                            mp3   = 1'b1;
                            phase = esdp_pkg::PH_REST;
                        end
                        esdp_pkg::OT_AAC: phase = esdp_pkg::PH_DSI_TAG;
                        OT_AAC_MAIN, OT_AAC_LC, OT_AAC_SSR:
                        begin
                            code = esdp_pkg::ST_AAC_13818;
                            return 1'b1;
                        end
                        default:
                        begin
                            code = esdp_pkg::ST_UNSUPPORTED;
                            return 1'b1;
                        end
                    endcase
                end
            end
            esdp_pkg::PH_DSI_TAG: open_tag(esdp_pkg::PH_DSI_LEN, b);
            esdp_pkg::PH_DSI_LEN:
                if (size_byte(b))
                begin
                    if (tag != esdp_pkg::TAG_DSI || len_acc == 0)
                    begin
                        code = esdp_pkg::ST_BAD_DSI;
                        return 1'b1;
                    end
                    dsi_offset = base_offset + pos + 48'd1;
                    dsi_length = len_acc;
                    phase      = esdp_pkg::PH_REST;
                end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function void record(esdp_pkg::status_t code);
        esds_status_t r;
        r.status       = code;
        r.is_mp3       = mp3;
        r.object_type  = obj_type;
        r.stream_type  = strm_type;
        r.extra_offset = dsi_offset;
        r.extra_length = dsi_length;
        awaited_status.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
        esdp_pkg::status_t code;
        if (phase == esdp_pkg::PH_ERROR)
        begin
            if (last)
                restart();
            else
                pos++;
            return;
        end
        if (parse_byte(b, code))
        begin
            record(code);
            if (last)
                restart();
            else
            begin
                phase = esdp_pkg::PH_ERROR;
                pos++;
            end
        end
        else if (last)
        begin
            record(phase == esdp_pkg::PH_REST ? esdp_pkg::ST_OK : esdp_pkg::ST_TRUNCATED);
            restart();
        end
        else
            pos++;
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_status(esds_status_t got);
        esds_status_t want;
        if (awaited_status.size() == 0)
        begin
            $display("%0t: status request with none expected, status %0d",
                     $time, got.status);
            mismatches++;
            return;
        end
        want = awaited_status.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("is_mp3", 64'(want.is_mp3), 64'(got.is_mp3));
        check_field("object_type", 64'(want.object_type), 64'(got.object_type));
        check_field("stream_type", 64'(want.stream_type), 64'(got.stream_type));
        check_field("extra_offset", 64'(want.extra_offset), 64'(got.extra_offset));
        check_field("extra_length", 64'(want.extra_length), 64'(got.extra_length));
    endfunction
endclass

module es_descriptor_parser_test;

    localparam logic [3:0] ADDR_BASE_OFFSET = 4'h0;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_BYTES   = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    esdp_byte_if   payload_ch();
    esdp_result_if result_ch();

    esds_parse_tracker sb = new();

    logic [7:0] atom_bytes[$];
    bit         sender_gaps;
    bit         receiver_stalls;
    bit         hold_long;
    int         bytes_sent;
    int         idle_cycles;

    es_descriptor_parser DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        esds_status_t got;
        if (payload_ch.valid === 1'b1 && payload_ch.ready === 1'b1)
            sb.take_byte(payload_ch.data_byte, payload_ch.last_byte);
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.status       = result_ch.status;
            got.is_mp3       = result_ch.is_mp3;
            got.object_type  = result_ch.object_type;
            got.stream_type  = result_ch.stream_type;
            got.extra_offset = result_ch.extra_offset;
            got.extra_length = result_ch.extra_length;
            sb.check_status(got);
        end
    end

    always @(posedge clk)
    begin
        if ((payload_ch.valid === 1'b1 && payload_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result receiver
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (receiver_stalls && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: return esdp_pkg::OT_AAC;
            6:  return OT_MPEG1_AUDIO;
            7:  return OT_MPEG2_AUDIO;
            8:  return 8'(OT_MPEG2_VIS_SIMPLE + $urandom_range(0, 5));
            9:  return 8'(OT_AAC_MAIN + $urandom_range(0, 2));
            10: return 8'(OT_MPEG4_VISUAL + $urandom_range(0, 1));
            11: return ($urandom_range(0, 1) != 0) ? OT_MPEG1_VISUAL : OT_JPEG;
            12: return OT_JPEG2000;
            default: return rand_byte();
        endcase
    endfunction

    function automatic logic [27:0] pick_size();
        case ($urandom_range(0, 15))
            0:       return '0;
            1, 2, 3: return 28'($urandom_range(0, 28'hFFFFFFF));
            default: return 28'($urandom_range(1, 100));
        endcase
    endfunction

    // groups == 0 picks a random count of at least the minimum
    task automatic put_size(input logic [27:0] value, input int groups);
        int         n;
        logic [7:0] b;
        n = (value < 28'h80) ? 1 : (value < 28'h4000) ? 2 : (value < 28'h200000) ? 3 : 4;
        if (groups == 0)
            n = $urandom_range(n, MAX_SIZE_GROUPS);
        else if (groups > n)
            n = groups;
        for (int i = n - 1; i >= 0; i--)
        begin
            // a full-length size may carry the continue bit on its final group
            b = {(i != 0) || (n == MAX_SIZE_GROUPS && $urandom_range(0, 1) != 0),
                 value[7 * i +: 7]};
            atom_bytes.push_back(b);
        end
    endtask

    task automatic make_atom(input logic [7:0] top_tag, input logic [2:0] flags,
                             input logic [7:0] url_len, input logic [7:0] dc_tag,
                             input logic [27:0] dc_len, input logic [7:0] ot,
                             input logic [7:0] dsi_tag, input logic [27:0] dsi_len,
                             input int rest, input int groups);
        atom_bytes.delete();
        atom_bytes.push_back(top_tag);
        put_size(28'($urandom_range(0, 28'hFFFFFFF)), groups);
        repeat (esdp_pkg::ID_SKIP) atom_bytes.push_back(rand_byte());
        atom_bytes.push_back({flags, 5'(rand_byte())});
        if ((flags & FLAG_DEP) != 0)
            repeat (esdp_pkg::ID_SKIP) atom_bytes.push_back(rand_byte());
        if ((flags & FLAG_URL) != 0)
        begin
            atom_bytes.push_back(url_len);
            repeat (url_len) atom_bytes.push_back(rand_byte());
        end
        if ((flags & FLAG_OCR) != 0)
            repeat (esdp_pkg::ID_SKIP) atom_bytes.push_back(rand_byte());
        atom_bytes.push_back(dc_tag);
        put_size(dc_len, groups);
        atom_bytes.push_back(ot);
        atom_bytes.push_back(rand_byte());
        repeat (esdp_pkg::DC_SKIP) atom_bytes.push_back(rand_byte());
        if (ot == esdp_pkg::OT_AAC)
        begin
            atom_bytes.push_back(dsi_tag);
            put_size(dsi_len, groups);
        end
        repeat (rest) atom_bytes.push_back(rand_byte());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            payload_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        payload_ch.valid     <= 1'b1;
        payload_ch.data_byte <= b;
        payload_ch.last_byte <= last;
        do
            @(posedge clk);
        while (payload_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_atom();
        int n;
        n = atom_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(atom_bytes[i], i == n - 1);
    endtask

    task automatic random_atom();
        int cut;
        if ($urandom_range(0, 15) == 0)
        begin
            // noise
            atom_bytes.delete();
            repeat ($urandom_range(1, 12)) atom_bytes.push_back(rand_byte());
        end
        else
        begin
            make_atom(($urandom_range(0, 15) == 0) ? rand_byte() : esdp_pkg::TAG_ES,
                      3'($urandom_range(0, 7)),
                      ($urandom_range(0, 15) == 0) ? rand_byte()
                                                   : 8'($urandom_range(0, 6)),
                      ($urandom_range(0, 15) == 0) ? rand_byte() : esdp_pkg::TAG_DC,
                      pick_size(), pick_type(),
                      ($urandom_range(0, 15) == 0) ? rand_byte() : esdp_pkg::TAG_DSI,
                      pick_size(), $urandom_range(0, 8), 0);
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, atom_bytes.size());
                while (atom_bytes.size() > cut)
                    void'(atom_bytes.pop_back());
            end
            if ($urandom_range(0, 7) == 0)
                atom_bytes[$urandom_range(0, atom_bytes.size() - 1)] = rand_byte();
        end
        send_atom();
    endtask

    task automatic wait_drained();
        payload_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [47:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BASE_OFFSET;
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.base_offset = value;
    endtask

    initial
    begin
        int          atoms;
        int          phase_start;
        logic [47:0] base;

        rst_n                <= 1'b0;
        payload_ch.valid     <= 1'b0;
        payload_ch.data_byte <= '0;
        payload_ch.last_byte <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_long       = 1'b0;
        bytes_sent      = 0;
        idle_cycles     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // good AAC, optional fields off, then all on with four-group sizes
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd20,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'd2, 2, 1);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_DEP | FLAG_URL | FLAG_OCR, 8'd3, esdp_pkg::TAG_DC,
                  28'hFFFFFFF, esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'hFFFFFFF, 0, 4);
        send_atom();
        // empty URL
        make_atom(esdp_pkg::TAG_ES, FLAG_URL, 8'd0, esdp_pkg::TAG_DC, 28'd1, OT_MPEG1_AUDIO,
                  esdp_pkg::TAG_DSI, 28'd0, 1, 2);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_DEP, 8'd0, esdp_pkg::TAG_DC, 28'd5, OT_MPEG2_AUDIO,
                  esdp_pkg::TAG_DSI, 28'd0, 0, 3);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_OCR, 8'd0, esdp_pkg::TAG_DC, 28'd9, OT_MPEG4_VISUAL,
                  esdp_pkg::TAG_DSI, 28'd0, 3, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9, OT_JPEG2000,
                  esdp_pkg::TAG_DSI, 28'd0, 1, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9, OT_AAC_MAIN,
                  esdp_pkg::TAG_DSI, 28'd0, 1, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9, OT_FORBIDDEN,
                  esdp_pkg::TAG_DSI, 28'd0, 0, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9, OT_UNSPECIFIED,
                  esdp_pkg::TAG_DSI, 28'd0, 2, 0);
        send_atom();
        // wrong top tag, wrong or empty decoder config, wrong or empty specific info
        make_atom(esdp_pkg::TAG_DSI, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'd4, 3, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DSI, 28'd9,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'd4, 0, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd0,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'd4, 0, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DC, 28'd4, 2, 0);
        send_atom();
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'd0, 2, 0);
        send_atom();
        // truncated mid-parse
        make_atom(esdp_pkg::TAG_ES, FLAG_NONE, 8'd0, esdp_pkg::TAG_DC, 28'd9,
                  esdp_pkg::OT_AAC, esdp_pkg::TAG_DSI, 28'd4, 0, 1);
        while (atom_bytes.size() > 10)
            void'(atom_bytes.pop_back());
        send_atom();
        // one-byte atom
        atom_bytes.delete();
        atom_bytes.push_back(esdp_pkg::TAG_ES);
        send_atom();
        // error decided on the last byte
        atom_bytes.delete();
        atom_bytes.push_back(esdp_pkg::TAG_DC);
        atom_bytes.push_back(8'h7f);
        send_atom();

        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            case (p)
                0:       base = 48'({$urandom, $urandom});
                1:       base = '1;
                2:       base = '0;
                3:       base = 48'($urandom_range(0, 1000));
                4:       base = 48'({$urandom, $urandom});
                default: base = 48'hFFFF_FFFF_FF00;
            endcase
            write_base(base);
            sender_gaps     = (p != 2 && p != 5);
            receiver_stalls = (p != 2 && p != 5);
            if (p == 1)
                hold_long = 1'b1;
            atoms       = 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                random_atom();
                atoms++;
                if (p == 3 && atoms % 3 == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
